// File: rtl/gmf_pkg.sv
`default_nettype none

package gmf_pkg;

   // fixed field widths of the ports
   localparam int ROWS_W     = 12;
   localparam int COLS_REG_W = 9;
   localparam int CSR_W      = 12;
   localparam int PEAK_COL_W = 8;

   // configuration register indexes
   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   // input opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // control that goes with one decision through the window stage
   typedef struct packed {
      logic live;       // stage holds an item
      logic dec;        // a cell is decided
      logic pre;        // capture column zero of the row just finished
      logic first;      // decided cell is in column zero
      logic cols_one;   // single column grid
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
   } gmf_probe_type;

endpackage

`default_nettype wire

// File: rtl/gmf_line_store.sv
`default_nettype none

module gmf_line_store
   import gmf_pkg::*;
#(
   parameter int AW = 9,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr_a,
   input  wire logic [AW-1:0] raddr_b,
   output logic      [DW-1:0] rdata_a,
   output logic      [DW-1:0] rdata_b
);

   localparam int DEPTH = 1 << AW;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_a_ff;
   logic [DW-1:0] rdata_b_ff;

   // read-first: a read of the address being written returns the old entry
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// File: rtl/gmf_window.sv
`default_nettype none

module gmf_window
   import gmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          step,
   input  wire gmf_probe_type                 probe,
   input  wire logic signed [SAMPLE_BITS-1:0] rd_right,
   input  wire logic signed [SAMPLE_BITS-1:0] rd_up,
   input  wire logic signed [SAMPLE_BITS-1:0] down,
   output logic                               peak
);

   // cells of the row above the incoming one: next row start, right, centre
   logic signed [SAMPLE_BITS-1:0] start_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic signed [SAMPLE_BITS-1:0] centre_ff;
   logic signed [SAMPLE_BITS-1:0] centre_now;
   logic                          up_ok;
   logic                          down_ok;
   logic                          left_ok;
   logic                          right_ok;

   // the old right cell becomes the centre, the old centre is the left neighbor
   assign centre_now = probe.first ? start_ff : right_ff;
   assign up_ok      = !probe.has_up    || (rd_up     <= centre_now);
   assign down_ok    = !probe.has_down  || (down      <= centre_now);
   assign left_ok    = !probe.has_left  || (centre_ff <= centre_now);
   assign right_ok   = !probe.has_right || (rd_right  <= centre_now);

   assign peak = probe.live && probe.dec && up_ok && down_ok && left_ok && right_ok;

   always_ff @(posedge clock) begin
      if (step) begin
         if (probe.dec) begin
            centre_ff <= centre_now;
            right_ff  <= rd_right;
         end
         if (probe.pre) begin
            start_ff <= probe.cols_one ? down : rd_right;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/grid_local_maximum_finder.sv
// Four-neighbor local maximum finder over a raster grid.
// req channel: one item per transfer; opcode sample carries a grid value in
// raster order, opcode drain decides the next cell of the last row once the
// whole grid has arrived. rsp channel: row and column of every cell that is
// greater than or equal to each neighbor inside the grid, in raster order.
// csr port: grid_rows (index 0) and grid_cols (index 1); any write restarts
// the grid. Write only while the block is idle.
// Throughput: one item per cycle while req_ready is high. An in-grid sample does
// one write and every item two reads of the two-row line store; the row above is
// kept in a chain of window cells, so nothing loops back within an item.
// Path to rsp: the line store is read at the edge that accepts the item, and
// the window compare then loads the output register, or the skid register
// while the receiver stalls.
// A stalled receiver fills the output register and a skid register; req_ready
// drops only when both are full and the window stage holds a result.
// Reset (synchronous): grid 1 x 1, positions zero, no results pending. The
// line store is not cleared; a grid only reads entries it wrote.
`default_nettype none

module grid_local_maximum_finder
   import gmf_pkg::*;
#(
   parameter int MAX_COLS    = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic              [ROWS_W-1:0]     rsp_peak_row,
   output logic              [PEAK_COL_W-1:0] rsp_peak_col,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic         [CSR_W-1:0]      csr_wdata
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int CNW = CW + 1;
   localparam int EXW = (CNW > COLS_REG_W) ? CNW : COLS_REG_W;
   localparam int AW  = CW + 1;

   // configuration and position registers
   logic [ROWS_W-1:0]     rows_ff;
   logic [COLS_REG_W-1:0] cols_ff;
   logic [ROWS_W-1:0]     row_ff;
   logic [CW-1:0]         col_ff;
   logic [CW-1:0]         drain_ff;

   logic [ROWS_W-1:0] rows_e;
   logic [EXW-1:0]    cols_x;
   logic [EXW-1:0]    cols_c;
   logic [CNW-1:0]    cols_e;
   logic [ROWS_W-1:0] last_row;
   logic [CNW-1:0]    col_n;
   logic [CNW-1:0]    col_next;
   logic [CNW-1:0]    drain_n;
   logic [CNW-1:0]    drain_next;
   logic              last_col;
   logic              drain_end;
   logic              grid_full;
   logic              sample_ok;
   logic              drain_ok;
   logic              drain_over;
   logic              is_drain;
   logic              acc;

   // line store access
   logic                   ls_we;
   logic [AW-1:0]          ls_waddr;
   logic [AW-1:0]          ls_raddr_a;
   logic [AW-1:0]          ls_raddr_b;
   logic [SAMPLE_BITS-1:0] ls_rdata_a;
   logic [SAMPLE_BITS-1:0] ls_rdata_b;

   // window stage
   gmf_probe_type                 s1_ff;
   gmf_probe_type                 s1_in;
   logic [ROWS_W-1:0]             s1_row_ff;
   logic [ROWS_W-1:0]             s1_row_in;
   logic [CW-1:0]                 s1_col_ff;
   logic [CW-1:0]                 s1_col_in;
   logic signed [SAMPLE_BITS-1:0] s1_down_ff;
   logic                          peak;
   logic                          s1_hold;
   logic                          s1_step;
   logic                          push;
   logic                          pop;

   // output register and skid register
   logic                  rsp_valid_ff;
   logic [ROWS_W-1:0]     rsp_row_ff;
   logic [PEAK_COL_W-1:0] rsp_col_ff;
   logic                  skid_valid_ff;
   logic [ROWS_W-1:0]     skid_row_ff;
   logic [PEAK_COL_W-1:0] skid_col_ff;

   // a register value of zero acts as one, columns clamp to the store depth
   assign rows_e   = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
   assign cols_x   = EXW'(cols_ff);
   assign cols_c   = (cols_x == '0) ? EXW'(1) :
                     ((cols_x > EXW'(MAX_COLS)) ? EXW'(MAX_COLS) : cols_x);
   assign cols_e   = CNW'(cols_c);
   assign last_row = rows_e - ROWS_W'(1);

   assign col_n      = CNW'(col_ff);
   assign col_next   = col_n + CNW'(1);
   assign drain_n    = CNW'(drain_ff);
   assign drain_next = drain_n + CNW'(1);
   assign last_col   = col_next >= cols_e;
   assign drain_end  = drain_next >= cols_e;
   assign grid_full  = row_ff >= rows_e;
   assign sample_ok  = !grid_full && (col_n < cols_e);
   assign drain_ok   = grid_full && (drain_n < cols_e);
   assign drain_over = grid_full && !(drain_n < cols_e);
   assign is_drain   = (req_opcode == OP_DRAIN);

   assign s1_hold   = peak && rsp_valid_ff && skid_valid_ff;
   assign req_ready = !s1_hold;
   assign acc       = req_valid && req_ready;
   assign s1_step   = s1_ff.live && !s1_hold;
   assign push      = peak && !s1_hold;
   assign pop       = rsp_valid_ff && rsp_ready;

   // line store addressing: bank is the row parity
   always_comb begin
      ls_we    = acc && !is_drain && sample_ok;
      ls_waddr = {row_ff[0], col_ff};
      if (is_drain) begin
         ls_raddr_a = {last_row[0], drain_next[CW-1:0]};
         ls_raddr_b = {~last_row[0], drain_ff};
      end else begin
         // at the end of a row the right port fetches column zero of that row
         ls_raddr_a = last_col ? {row_ff[0], CW'(0)} : {~row_ff[0], col_next[CW-1:0]};
         ls_raddr_b = {row_ff[0], col_ff};
      end
   end

   // what the accepted item asks of the window stage
   always_comb begin
      s1_in = '0;
      if (is_drain) begin
         s1_in.dec       = drain_ok;
         s1_in.has_up    = last_row != '0;
         s1_in.has_left  = drain_ff != '0;
         s1_in.has_right = !drain_end;
         s1_in.first     = drain_ff == '0;
         s1_row_in       = last_row;
         s1_col_in       = drain_ff;
      end else begin
         s1_in.dec       = sample_ok && (row_ff != '0);
         s1_in.pre       = sample_ok && last_col;
         s1_in.has_up    = row_ff >= ROWS_W'(2);
         s1_in.has_down  = 1'b1;
         s1_in.has_left  = col_ff != '0;
         s1_in.has_right = !last_col;
         s1_in.first     = col_ff == '0;
         s1_row_in       = row_ff - ROWS_W'(1);
         s1_col_in       = col_ff;
      end
      s1_in.cols_one = cols_e == CNW'(1);
      s1_in.live     = acc && (s1_in.dec || s1_in.pre);
   end

   // configuration and grid positions
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_W'(1);
         cols_ff  <= COLS_REG_W'(1);
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_ROWS: rows_ff <= csr_wdata[ROWS_W-1:0];
            CSR_GRID_COLS: cols_ff <= csr_wdata[COLS_REG_W-1:0];
            default:       rows_ff <= rows_ff;
         endcase
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else if (acc) begin
         if (!is_drain) begin
            if (sample_ok) begin
               if (last_col) begin
                  col_ff <= '0;
                  row_ff <= row_ff + ROWS_W'(1);
               end else begin
                  col_ff <= col_next[CW-1:0];
               end
            end
         end else if (drain_over || (drain_ok && drain_end)) begin
            row_ff   <= '0;
            col_ff   <= '0;
            drain_ff <= '0;
         end else if (drain_ok) begin
            drain_ff <= drain_next[CW-1:0];
         end
      end
   end

   // window stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (!s1_hold) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_row_ff  <= s1_row_in;
         s1_col_ff  <= s1_col_in;
         s1_down_ff <= req_sample_value;
      end
   end

   gmf_line_store #(
      .AW (AW),
      .DW (SAMPLE_BITS)
   ) u_line_store (
      .clock   (clock),
      .we      (ls_we),
      .waddr   (ls_waddr),
      .wdata   (req_sample_value),
      .re      (acc),
      .raddr_a (ls_raddr_a),
      .raddr_b (ls_raddr_b),
      .rdata_a (ls_rdata_a),
      .rdata_b (ls_rdata_b)
   );

   gmf_window #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock    (clock),
      .step     (s1_step),
      .probe    (s1_ff),
      .rd_right ($signed(ls_rdata_a)),
      .rd_up    ($signed(ls_rdata_b)),
      .down     (s1_down_ff),
      .peak     (peak)
   );

   // output register with skid: the skid only fills while the head waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_row_ff <= skid_row_ff;
            rsp_col_ff <= skid_col_ff;
         end else begin
            rsp_row_ff <= s1_row_ff;
            rsp_col_ff <= PEAK_COL_W'(s1_col_ff);
         end
      end else if (push) begin
         skid_row_ff <= s1_row_ff;
         skid_col_ff <= PEAK_COL_W'(s1_col_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_peak_row = rsp_row_ff;
   assign rsp_peak_col = rsp_col_ff;

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_hold_keeps_item: assert property (@(posedge clock) disable iff (reset)
      s1_hold |=> (s1_ff.live && s1_ff.dec))
      else $error("held window stage lost its decision");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      row_ff <= rows_e)
      else $error("row position beyond the grid");

   a_drain_after_grid: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> grid_full)
      else $error("drain position moved before the grid was complete");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid_ff && !pop) |=> skid_valid_ff)
      else $error("result lost while the receiver stalled");

endmodule

`default_nettype wire
